@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/sswr_pkg.sv @@
// ----------------------------------------------------------------------------
// sswr_pkg
// widths, register indexes and checksum helper of the settings word receiver
// ----------------------------------------------------------------------------
package sswr_pkg;

    // field widths
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 8;
    localparam int CFG_IDX_W = 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_WORD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_COUNT   = 1'b1;

    // reset values and constants
    localparam logic [COUNT_W-1:0] STABLE_COUNT_RESET = 8'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX          = 8'hFF;
    localparam logic [7:0]         CHECK_SEED         = 8'hAA;

    // byte 3 must equal the low byte of seed plus bytes 0 to 2
    function automatic logic checksum_ok(input logic [WORD_W-1:0] word);
        logic [7:0] sum;
        sum = CHECK_SEED + word[7:0] + word[15:8] + word[23:16];
        return word[31:24] == sum;
    endfunction

endpackage

@@ rtl/stable_settings_word_receiver.sv @@
// ----------------------------------------------------------------------------
// stable_settings_word_receiver
// waits for a new settings word, checks that it repeats long enough,
// verifies its checksum and then locks and reports it on every later word
// ----------------------------------------------------------------------------
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+------------------------------
//  slot in   | in        | i_valid / o_stall   | i_slot_word
//  result    | out       | o_valid / i_stall   | o_settings_valid,
//            |           |                     | o_settings_word
//  config    | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
//  one word per cycle while o_stall is low; each result is registered in the output register or skid entry
//  the receiver state update and result are computed combinationally
//  a two-entry output buffer (output register plus skid) keeps o_stall
//  registered, so a stall on the result side reaches the input through the skid entry
//  synchronous active-low reset; no clearing pass is needed
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stable_settings_word_receiver (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slot word input
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [sswr_pkg::WORD_W-1:0]  i_slot_word,
    // result output
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_settings_valid,
    output logic [sswr_pkg::WORD_W-1:0]  o_settings_word,
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [sswr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sswr_pkg::WORD_W-1:0]  i_cfg_data
);
    import sswr_pkg::*;

    typedef enum logic [1:0] {
        PH_WAITING,
        PH_RECEIVING,
        PH_TESTING,
        PH_LOCKED
    } t_phase;

    // receiver state
    t_phase               r_phase,         n_phase;
    logic [WORD_W-1:0]    r_previous_word, n_previous_word;
    logic [COUNT_W-1:0]   r_repeat_count,  n_repeat_count;
    logic [WORD_W-1:0]    r_captured_word, n_captured_word;
    logic [WORD_W-1:0]    r_reference_word;
    logic [COUNT_W-1:0]   r_stable_count;

    // output register and skid stage
    logic                 r_out_valid;
    logic                 r_out_settings_valid;
    logic [WORD_W-1:0]    r_out_settings_word;
    logic                 r_skid_valid;
    logic                 r_skid_settings_valid;
    logic [WORD_W-1:0]    r_skid_settings_word;

    logic                 in_accept;
    logic                 out_accept;
    logic                 n_settings_valid;
    logic [COUNT_W-1:0]   repeat_inc;

    assign o_stall    = r_skid_valid;
    assign in_accept  = i_valid && !r_skid_valid;
    assign out_accept = r_out_valid && !i_stall;

    assign o_valid          = r_out_valid;
    assign o_settings_valid = r_out_settings_valid;
    assign o_settings_word  = r_out_settings_word;

    // saturating repeat counter
    assign repeat_inc = (r_repeat_count == COUNT_MAX) ? COUNT_MAX
                                                      : r_repeat_count + 1'b1;

    // next state of the receiver for the incoming word
    always_comb begin
        n_phase          = r_phase;
        n_repeat_count   = r_repeat_count;
        n_captured_word  = r_captured_word;
        n_previous_word  = i_slot_word;
        n_settings_valid = 1'b0;
        unique case (r_phase)
            PH_WAITING: begin
                if (i_slot_word != r_reference_word) begin
                    n_phase = PH_RECEIVING;
                end
            end
            PH_RECEIVING: begin
                if (i_slot_word == r_previous_word) begin
                    if (repeat_inc > r_stable_count) begin
                        n_captured_word = i_slot_word;
                        n_repeat_count  = '0;
                        n_phase         = PH_TESTING;
                    end else begin
                        n_repeat_count = repeat_inc;
                    end
                end else begin
                    n_repeat_count = '0;
                    n_phase        = PH_WAITING;
                end
            end
            PH_TESTING: begin
                n_phase = checksum_ok(r_captured_word) ? PH_LOCKED : PH_WAITING;
            end
            PH_LOCKED: begin
                n_settings_valid = 1'b1;
            end
            default: begin
                n_phase = PH_WAITING;
            end
        endcase
    end

    // configuration and receiver state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_WAITING;
            r_previous_word  <= '0;
            r_repeat_count   <= '0;
            r_captured_word  <= '0;
            r_reference_word <= '0;
            r_stable_count   <= STABLE_COUNT_RESET;
        end else begin
            if (in_accept) begin
                r_phase         <= n_phase;
                r_previous_word <= n_previous_word;
                r_repeat_count  <= n_repeat_count;
                r_captured_word <= n_captured_word;
            end
            // a reference write restarts the receiver
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_REFERENCE_WORD: begin
                        r_reference_word <= i_cfg_data;
                        r_phase          <= PH_WAITING;
                        r_repeat_count   <= '0;
                        r_previous_word  <= '0;
                    end
                    REG_STABLE_COUNT: begin
                        r_stable_count <= i_cfg_data[COUNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // output buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_accept) begin
                r_out_valid  <= r_skid_valid || in_accept;
                r_skid_valid <= 1'b0;
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // output buffer payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_accept) begin
            if (r_skid_valid) begin
                r_out_settings_valid <= r_skid_settings_valid;
                r_out_settings_word  <= r_skid_settings_word;
            end else begin
                r_out_settings_valid <= n_settings_valid;
                r_out_settings_word  <= n_captured_word;
            end
        end
        if (in_accept) begin
            r_skid_settings_valid <= n_settings_valid;
            r_skid_settings_word  <= n_captured_word;
        end
    end

    // skid entry only holds a word behind a waiting output word
    `ASSERT_CLK(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid,
        "skid word without output word")

    // repeat count only runs while receiving
    `ASSERT_CLK(a_count_idle, i_clk, i_rst_n,
        r_phase != PH_RECEIVING |-> r_repeat_count == '0,
        "repeat count nonzero outside receiving")

    // a reference write always restarts reception
    `ASSERT_CLK(a_ref_restart, i_clk, i_rst_n,
        (i_cfg_we && i_cfg_index == REG_REFERENCE_WORD) |=>
        (r_phase == PH_WAITING && r_previous_word == '0),
        "reference write did not restart receiver")

    // testing lasts exactly one word
    `ASSERT_CLK(a_test_one_word, i_clk, i_rst_n,
        (in_accept && !i_cfg_we && r_phase == PH_TESTING) |=>
        (r_phase == PH_LOCKED || r_phase == PH_WAITING),
        "testing phase held past one word")

    // buffer empties under reset
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_out_valid && !r_skid_valid),
        "output buffer not empty after reset")

endmodule
